[src/sha256_pkg.sv]
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_COMP,
      ST_FIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load_byte;
      logic       pad_byte;
      logic       zero_byte;
      logic       len_byte;
      logic       comp_start;
      logic       comp_round;
      logic       comp_finish;
      logic       emit_shift;
      logic       init_all;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic [5:0] round;
   } status_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      begin
         unique case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa704;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
         endcase
         return k;
      end
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h;
      begin
         unique case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
         endcase
         return h;
      end
   endfunction

endpackage

[src/sha256_if.sv]
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       has_byte;
   logic       last_byte;
   modport source (output valid, message_byte, has_byte, last_byte, input ready);
   modport sink (input valid, message_byte, has_byte, last_byte, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[src/sha256_dp.sv]
module sha256_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  sha256_pkg::cmd_type   cmd,
   input  logic [7:0]            in_byte,
   output sha256_pkg::status_type status,
   output logic [31:0]           digest_word
);

   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [60:0] len_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  round_ff;
   logic [63:0] bits;
   logic [7:0]  wr_byte;
   logic        wr_en;
   logic [31:0] w_new, s0, s1, big0, big1, ch, maj, t1, t2, wcur;

   assign bits = {len_ff, 3'b000};
   assign status.fill = fill_ff;
   assign status.round = round_ff;
   assign digest_word = h_ff[0];

   always_comb begin
      wr_en = cmd.load_byte | cmd.pad_byte | cmd.zero_byte | cmd.len_byte;
      wr_byte = 8'h00;
      if (cmd.load_byte) begin
         wr_byte = in_byte;
      end else if (cmd.pad_byte) begin
         wr_byte = sha256_pkg::PAD_BYTE;
      end else if (cmd.len_byte) begin
         wr_byte = bits[8*(7 - fill_ff[2:0]) +: 8];
      end
   end

   // message schedule runs as a 16-word shift window
   always_comb begin
      wcur = w_ff[0];
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]} ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
           ^ (w_ff[14] >> 10);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
      big1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
             ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + big1 + ch + sha256_pkg::round_k(round_ff) + wcur;
      big0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
             ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = big0 + maj;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         w_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= wr_byte;
      end
      if (cmd.comp_start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end
      if (cmd.comp_round) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init_all) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::init_hash(3'(i));
         len_ff <= '0;
         fill_ff <= '0;
         round_ff <= '0;
      end else begin
         if (wr_en) fill_ff <= fill_ff + 6'd1;
         if (cmd.load_byte) len_ff <= len_ff + 61'd1;
         if (cmd.comp_start) round_ff <= '0;
         if (cmd.comp_round) round_ff <= round_ff + 6'd1;
         if (cmd.comp_finish) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end
         if (cmd.emit_shift) begin
            for (int i = 0; i < 7; i++) h_ff[i] <= h_ff[i+1];
            h_ff[7] <= h_ff[0];
         end
      end
   end

endmodule

[src/sha256_ctrl.sv]
module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   sha256_req_if.sink             req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_index,
   input  sha256_pkg::status_type status,
   output sha256_pkg::cmd_type    cmd
);

   sha256_pkg::state_type state_ff, state_in;
   logic final_ff, final_in;
   logic finish_ff, finish_in;
   logic lenblk_ff, lenblk_in;
   logic [2:0] idx_ff, idx_in;
   logic hs;

   assign rsp_valid = (state_ff == sha256_pkg::ST_EMIT);
   assign rsp_index = idx_ff;
   assign req.ready = (state_ff == sha256_pkg::ST_IDLE);
   assign hs = req.valid & req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         final_ff <= 1'b0;
         finish_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         finish_ff <= finish_in;
         lenblk_ff <= lenblk_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      finish_in = finish_ff;
      lenblk_in = lenblk_ff;
      idx_in = idx_ff;
      cmd = '0;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (hs) begin
               cmd.load_byte = req.has_byte;
               final_in = req.last_byte;
               finish_in = req.last_byte;
               if (req.has_byte && status.fill == 6'd63) begin
                  cmd.comp_start = 1'b1;
                  state_in = sha256_pkg::ST_COMP;
               end else if (req.last_byte) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            // 0x80 once, then zeros up to the length field or block end
            if (final_ff) begin
               cmd.pad_byte = 1'b1;
               final_in = 1'b0;
            end else begin
               cmd.zero_byte = 1'b1;
            end
            if (status.fill == 6'd63) begin
               cmd.comp_start = 1'b1;
               state_in = sha256_pkg::ST_COMP;
            end else if (status.fill == 6'd55) begin
               state_in = sha256_pkg::ST_LEN;
            end
         end
         sha256_pkg::ST_LEN: begin
            cmd.len_byte = 1'b1;
            lenblk_in = 1'b1;
            if (status.fill == 6'd63) begin
               cmd.comp_start = 1'b1;
               state_in = sha256_pkg::ST_COMP;
            end
         end
         sha256_pkg::ST_COMP: begin
            cmd.comp_round = 1'b1;
            if (status.round == 6'd63) begin
               state_in = sha256_pkg::ST_FIN;
            end
         end
         sha256_pkg::ST_FIN: begin
            // fold the working words in after the last round has landed
            cmd.comp_finish = 1'b1;
            if (lenblk_ff) state_in = sha256_pkg::ST_EMIT;
            else if (finish_ff) state_in = sha256_pkg::ST_PAD;
            else state_in = sha256_pkg::ST_IDLE;
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               cmd.emit_shift = 1'b1;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.init_all = 1'b1;
                  finish_in = 1'b0;
                  lenblk_in = 1'b0;
                  state_in = sha256_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

endmodule

[src/sha256_stream_hasher_top.sv]
// Channel  Dir  Payload
// req      in   message_byte[7:0], has_byte, last_byte
// rsp      out  digest_word[31:0], word_index[2:0], last_word
//
// Byte beats are taken one per cycle while idle; the 64th byte of a block starts
// 64 rounds at one per cycle in the shared compression datapath, then one fold.
// A last beat adds padding and length bytes at one per cycle, one or two
// compressions, then eight digest beats.
// Synchronous reset restores the initial hash values; rsp stalls hold state.
module sha256_stream_hasher_top (
   input logic         clock,
   input logic         reset,
   sha256_req_if.sink  req,
   sha256_rsp_if.source rsp
);

   sha256_pkg::cmd_type    cmd;
   sha256_pkg::status_type status;
   logic [2:0]             idx;

   sha256_ctrl u_ctrl (
      .clock, .reset, .req,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_index(idx),
      .status, .cmd
   );

   sha256_dp u_dp (
      .clock, .reset, .cmd, .in_byte(req.message_byte), .status,
      .digest_word(rsp.digest_word)
   );

   assign rsp.word_index = idx;
   assign rsp.last_word = (idx == 3'd7);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready)) else $error("input taken during output");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.word_index))
      else $error("index moved under stall");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_word |=> req.ready)
      else $error("not idle after digest");

endmodule

[test/sha256_stream_hasher_top_tb.sv]
module sha256_stream_hasher_top_tb;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       has_byte;
      logic       last_byte;
   } byte_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   localparam int unsigned ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa704,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam int unsigned IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha256_req_if req ();
   sha256_rsp_if rsp ();

   sha256_stream_hasher_top i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   byte_beat_type   pending_bytes[$];
   digest_beat_type expected_digest[$];
   logic [31:0]     hash_state[8];
   logic [7:0]      msg_block[64];
   logic [60:0]     msg_len;
   int              mismatches = 0;
   bit              hold_rsp = 1'b0;
   bit              hold_req = 1'b0;
   int              burst_left = 0;
   int              gap_left = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_msg_block();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
      msg_len = '0;
   endfunction

   function automatic void hash_byte_beat(byte_beat_type b);
      int idx;
      logic [63:0] bits;
      digest_beat_type d;
      if (b.has_byte) begin
         msg_block[msg_len[5:0]] = b.message_byte;
         msg_len = msg_len + 1'b1;
         if (msg_len[5:0] == 0) compress_msg_block();
      end
      if (!b.last_byte) return;
      idx = msg_len[5:0];
      msg_block[idx] = sha256_pkg::PAD_BYTE;
      idx++;
      if (idx > 56) begin
         for (int i = idx; i < 64; i++) msg_block[i] = 8'h00;
         compress_msg_block();
         idx = 0;
      end
      for (int i = idx; i < 56; i++) msg_block[i] = 8'h00;
      bits = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
         d.digest_word = hash_state[i];
         d.word_index  = 3'(i);
         d.last_word   = (i == 7);
         expected_digest.push_back(d);
      end
      restart_message();
   endfunction

   function automatic void queue_message(int len, bit empty_end);
      byte_beat_type b;
      for (int i = 0; i < len; i++) begin
         b.message_byte = 8'($urandom);
         b.has_byte = 1'b1;
         b.last_byte = (!empty_end && i == len - 1);
         pending_bytes.push_back(b);
         // sprinkle ignored beats
         if ($urandom_range(0, 31) == 0)
            pending_bytes.push_back(byte_beat_type'({8'($urandom), 2'b00}));
      end
      if (empty_end || len == 0)
         pending_bytes.push_back(byte_beat_type'({8'($urandom), 2'b01}));
   endfunction

   // driver
   always @(posedge clock) begin
      byte_beat_type b;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         if (gap_left == 0 && !hold_req && pending_bytes.size() > 0) begin
            b = pending_bytes.pop_front();
            req.valid <= 1'b1;
            req.message_byte <= b.message_byte;
            req.has_byte <= b.has_byte;
            req.last_byte <= b.last_byte;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // predictor runs on each accepted beat
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         hash_byte_beat(byte_beat_type'({req.message_byte, req.has_byte, req.last_byte}));
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      digest_beat_type got, want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !hold_rsp && ($urandom_range(0, 3) != 0 || expected_digest.size() > 16);
         if (rsp.valid && rsp.ready) begin
            got = {rsp.digest_word, rsp.word_index, rsp.last_word};
            if (expected_digest.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected digest beat %h", got);
            end else begin
               want = expected_digest.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("digest mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                        want.digest_word, want.word_index, want.last_word,
                        got.digest_word, got.word_index, got.last_word);
               end
            end
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.message_byte = '0;
      req.has_byte = 1'b0;
      req.last_byte = 1'b0;
      rsp.ready = 1'b0;
      restart_message();
      // directed: empty message, extremes, padding boundaries
      pending_bytes.push_back(byte_beat_type'({8'h00, 2'b00}));
      pending_bytes.push_back(byte_beat_type'({8'hff, 2'b01}));
      pending_bytes.push_back(byte_beat_type'({8'hff, 2'b11}));
      pending_bytes.push_back(byte_beat_type'({8'h00, 2'b10}));
      pending_bytes.push_back(byte_beat_type'({8'h55, 2'b10}));
      pending_bytes.push_back(byte_beat_type'({8'haa, 2'b11}));
      // pad byte lands at the block end: extra block
      queue_message(63, 1'b1);
      queue_message(40, 1'b0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // long receiver hold-off while bytes keep coming
      hold_rsp <= 1'b1;
      repeat (600) @(posedge clock);
      hold_rsp <= 1'b0;
      wait (pending_bytes.size() == 0 && !req.valid && expected_digest.size() == 0);
      repeat (200) @(posedge clock);
      for (int m = 0; m < 4; m++) begin
         queue_message($urandom_range(0, 6), $urandom_range(0, 3) == 0);
         if (m == 1) begin
            // pause the sender until every pending digest is out
            hold_req <= 1'b1;
            @(posedge clock);
            wait (expected_digest.size() == 0);
            repeat (150) @(posedge clock);
            hold_req <= 1'b0;
         end
      end
      wait (pending_bytes.size() == 0 && !req.valid);
      wait (expected_digest.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_digest.size() == 0)
         $display("[sha256_stream_hasher_top] OK");
      else
         $display("[sha256_stream_hasher_top] ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("[sha256_stream_hasher_top] ERROR");
      $finish;
   end

endmodule
